FILE: hdl/tcaoq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcaoq_pkg
// Shared types and codes for the two-class age-ordered queue unit.
// ----------------------------------------------------------------------------
package tcaoq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int STAMP_BITS_DEF  = 16;
  localparam int TAG_BITS        = 16;

  localparam logic [2:0] ACT_ENQ_A   = 3'd0;
  localparam logic [2:0] ACT_ENQ_B   = 3'd1;
  localparam logic [2:0] ACT_DEQ_ANY = 3'd2;
  localparam logic [2:0] ACT_DEQ_A   = 3'd3;
  localparam logic [2:0] ACT_DEQ_B   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  typedef struct packed {
    logic [2:0]          action;
    logic [TAG_BITS-1:0] item_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TAG_BITS-1:0] out_tag;
    logic                out_class;
    logic                out_valid;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: hdl/tcaoq_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcaoq_fifo
// One class queue: entry memory of {stamp, tag} with registered head read,
// head and tail pointers and an occupancy count.
// ----------------------------------------------------------------------------
module tcaoq_fifo
  import tcaoq_pkg::*;
#(
  parameter int DEPTH      = QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fifo_ctrl_t            ctrl,
  input  wire logic [STAMP_BITS-1:0] wr_stamp,
  input  wire logic [TAG_BITS-1:0]   wr_tag,
  output fifo_stat_t                 stat,
  output logic [STAMP_BITS-1:0]      head_stamp,
  output logic [TAG_BITS-1:0]        head_tag
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = STAMP_BITS + TAG_BITS;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   tail_next;
  logic [CNT_W-1:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  assign head_next = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == IDX_W'(DEPTH - 1)) ? '0 : tail + 1'b1;

  assign head_stamp = rd_data[ENTRY_W-1:TAG_BITS];
  assign head_tag   = rd_data[TAG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= {wr_stamp, wr_tag};
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) begin
        tail  <= tail_next;
        count <= count + 1'b1;
      end else if (ctrl.pop) begin
        head  <= head_next;
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> !stat.full && !ctrl.pop)
    else $error("push into full queue or with pop");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hdl/two_class_age_ordered_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue_unit
// Two class queues with arrival stamps; dequeue-any returns the older head.
// ----------------------------------------------------------------------------
// result: a request accepted at one edge has its result on rsp with done
//   high in the cycle after the next edge
// flow: busy is high in the execute state; a new request is taken only once
//   the unit is back in idle, after the previous result has been registered
// reset: pointers, counts and the arrival counter clear; entry memories are
//   not cleared; done is held low, and rsp is not cleared
module two_class_age_ordered_queue_unit
  import tcaoq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state;
  logic [2:0]            action;
  logic [TAG_BITS-1:0]   tag;
  logic [STAMP_BITS-1:0] counter;

  fifo_ctrl_t            ctrl_a;
  fifo_ctrl_t            ctrl_b;
  fifo_stat_t            stat_a;
  fifo_stat_t            stat_b;
  logic [STAMP_BITS-1:0] stamp_a;
  logic [STAMP_BITS-1:0] stamp_b;
  logic [TAG_BITS-1:0]   tag_a;
  logic [TAG_BITS-1:0]   tag_b;
  logic [STAMP_BITS-1:0] diff;
  logic                  a_older;
  rsp_t                  rsp_next;
  logic                  exec;

  assign busy = (state != S_IDLE);
  assign exec = (state == S_EXEC);

  tcaoq_fifo #(.DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_fifo_a (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_a),
    .wr_stamp   (counter),
    .wr_tag     (tag),
    .stat       (stat_a),
    .head_stamp (stamp_a),
    .head_tag   (tag_a)
  );

  tcaoq_fifo #(.DEPTH(QUEUE_DEPTH), .STAMP_BITS(STAMP_BITS)) u_fifo_b (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_b),
    .wr_stamp   (counter),
    .wr_tag     (tag),
    .stat       (stat_b),
    .head_stamp (stamp_b),
    .head_tag   (tag_b)
  );

  // wrap-safe age compare of the two heads
  assign diff    = stamp_b - stamp_a;
  assign a_older = (diff != '0) && !diff[STAMP_BITS-1];

  always_comb begin
    ctrl_a   = '0;
    ctrl_b   = '0;
    rsp_next = '0;
    case (action)
      ACT_ENQ_A: begin
        if (stat_a.full) rsp_next.status = ST_FULL;
        else ctrl_a.push = exec;
      end
      ACT_ENQ_B: begin
        if (stat_b.full) rsp_next.status = ST_FULL;
        else ctrl_b.push = exec;
      end
      ACT_DEQ_ANY: begin
        if (stat_a.empty && stat_b.empty) begin
          rsp_next.status = ST_EMPTY;
        end else if (stat_b.empty || (!stat_a.empty && a_older)) begin
          ctrl_a.pop         = exec;
          rsp_next.out_tag   = tag_a;
          rsp_next.out_class = CLASS_A;
          rsp_next.out_valid = 1'b1;
        end else begin
          ctrl_b.pop         = exec;
          rsp_next.out_tag   = tag_b;
          rsp_next.out_class = CLASS_B;
          rsp_next.out_valid = 1'b1;
        end
      end
      ACT_DEQ_A: begin
        if (stat_a.empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          ctrl_a.pop         = exec;
          rsp_next.out_tag   = tag_a;
          rsp_next.out_class = CLASS_A;
          rsp_next.out_valid = 1'b1;
        end
      end
      ACT_DEQ_B: begin
        if (stat_b.empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          ctrl_b.pop         = exec;
          rsp_next.out_tag   = tag_b;
          rsp_next.out_class = CLASS_B;
          rsp_next.out_valid = 1'b1;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      counter <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (ctrl_a.push || ctrl_b.push) counter <= counter + 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      action <= req.action;
      tag    <= req.item_tag;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_EXEC)
    else $error("result without execute cycle");

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("accepted request gave no result");

  a_valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.out_valid |-> rsp.status == ST_OK)
    else $error("dequeued item with error status");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    $countones({ctrl_a.push, ctrl_a.pop, ctrl_b.push, ctrl_b.pop}) <= 1)
    else $error("more than one queue update per request");

endmodule

`default_nettype wire

FILE: test/two_class_age_ordered_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// two_class_age_ordered_queue_unit_tb
// Self-checking bench for the two-class age-ordered queue unit. Requests are
// sent through the start/busy handshake with random idle gaps. Each accepted
// request updates a local copy of both class queues and the arrival stamp,
// which yields the expected result. Results marked by done are compared
// field by field, in order. The bench covers empty and full queues, unused
// action codes, age order between the classes and random traffic.
// ----------------------------------------------------------------------------
module two_class_age_ordered_queue_unit_tb;
  import tcaoq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOW_LIMIT = 10;
  localparam logic [2:0] ACT_NOP_LO = 3'd5;
  localparam logic [2:0] ACT_NOP_HI = 3'd7;

  typedef logic [STAMP_BITS_DEF-1:0] stamp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // local copy of both class queues, indexed by class
  logic [TAG_BITS-1:0] model_tag [2][QUEUE_DEPTH_DEF];
  stamp_t model_stamp [2][QUEUE_DEPTH_DEF];
  int model_head [2] = '{default: 0};
  int model_tail [2] = '{default: 0};
  int model_count [2] = '{default: 0};
  stamp_t model_arrival = '0;

  rsp_t expected_q [$];
  rsp_t want_rsp;
  logic gaps_on = 1'b1;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_taken = 0;
  int n_full = 0;
  int n_empty = 0;

  two_class_age_ordered_queue_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t model_take(logic cls);
    rsp_t res;
    res = '0;
    if (model_count[cls] == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_OK;
      res.out_tag = model_tag[cls][model_head[cls]];
      res.out_class = cls;
      res.out_valid = 1'b1;
      model_head[cls] = (model_head[cls] + 1) % QUEUE_DEPTH_DEF;
      model_count[cls]--;
    end
    return res;
  endfunction

  function automatic rsp_t predict_queue_result(req_t r);
    rsp_t res;
    logic cls;
    stamp_t age_gap;
    res = '0;
    case (r.action)
      ACT_ENQ_A, ACT_ENQ_B: begin
        cls = (r.action == ACT_ENQ_B) ? CLASS_B : CLASS_A;
        if (model_count[cls] == QUEUE_DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          model_tag[cls][model_tail[cls]] = r.item_tag;
          model_stamp[cls][model_tail[cls]] = model_arrival;
          model_tail[cls] = (model_tail[cls] + 1) % QUEUE_DEPTH_DEF;
          model_count[cls]++;
          model_arrival = model_arrival + 1'b1;
          res.status = ST_OK;
        end
      end
      ACT_DEQ_ANY: begin
        if (model_count[CLASS_A] == 0) begin
          cls = CLASS_B;
        end else if (model_count[CLASS_B] == 0) begin
          cls = CLASS_A;
        end else begin
          // wrap-safe age compare, equal stamps go to class B
          age_gap = model_stamp[CLASS_B][model_head[CLASS_B]]
                  - model_stamp[CLASS_A][model_head[CLASS_A]];
          cls = (age_gap != '0 && !age_gap[STAMP_BITS_DEF-1]) ? CLASS_A : CLASS_B;
        end
        res = model_take(cls);
      end
      ACT_DEQ_A: res = model_take(CLASS_A);
      ACT_DEQ_B: res = model_take(CLASS_B);
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [2:0] random_action(int mode);
    int r;
    int enq_pct;
    r = $urandom_range(0, 99);
    enq_pct = (mode == 1) ? 72 : (mode == 2) ? 22 : 46;
    if (r < 3) return 3'($urandom_range(ACT_NOP_LO, ACT_NOP_HI));
    if (r < 3 + enq_pct) return $urandom_range(0, 1) ? ACT_ENQ_B : ACT_ENQ_A;
    r = $urandom_range(0, 2);
    return (r == 0) ? ACT_DEQ_ANY : (r == 1) ? ACT_DEQ_A : ACT_DEQ_B;
  endfunction

  task automatic send_request(input logic [2:0] act, input logic [TAG_BITS-1:0] tag);
    req_t r;
    int g;
    r.action = act;
    r.item_tag = tag;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_queue_result(r));
    n_requests++;
    g = idle_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) begin
      $display("[%0t] %s: expected status=%0d tag=%h class=%0d valid=%0d,",
               $realtime, what, want.status, want.out_tag, want.out_class, want.out_valid);
      $display("    got status=%0d tag=%h class=%0d valid=%0d",
               got.status, got.out_tag, got.out_class, got.out_valid);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (rsp.out_valid === 1'b1) n_taken++;
      if (rsp.status === ST_FULL) n_full++;
      if (rsp.status === ST_EMPTY) n_empty++;
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result", '0, rsp);
      end else begin
        want_rsp = expected_q.pop_front();
        if (rsp.status !== want_rsp.status || rsp.out_tag !== want_rsp.out_tag ||
            rsp.out_class !== want_rsp.out_class || rsp.out_valid !== want_rsp.out_valid) begin
          note_mismatch("result mismatch", want_rsp, rsp);
        end
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_empty_and_noop();
    send_request(ACT_DEQ_ANY, 16'hFFFF);
    send_request(ACT_DEQ_A, 16'h0000);
    send_request(ACT_DEQ_B, 16'hFFFF);
    send_request(ACT_NOP_LO, 16'hFFFF);
    send_request(ACT_NOP_LO + 3'd1, 16'h0000);
    send_request(ACT_NOP_HI, 16'hA5A5);
  endtask

  task automatic test_age_order();
    send_request(ACT_ENQ_A, 16'h0000);
    send_request(ACT_ENQ_B, 16'hFFFF);
    send_request(ACT_ENQ_A, 16'h1234);
    send_request(ACT_DEQ_ANY, 16'h0000);
    send_request(ACT_DEQ_ANY, 16'h0000);
    send_request(ACT_DEQ_ANY, 16'h0000);
    send_request(ACT_DEQ_ANY, 16'hFFFF);
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      send_request(ACT_ENQ_B, 16'($urandom_range(0, 16'hFFFF)));
    end
    send_request(ACT_ENQ_B, 16'hFFFF);
    send_request(ACT_ENQ_A, 16'h8001);
    send_request(ACT_DEQ_ANY, 16'h0000);
  endtask

  task automatic test_random_mix();
    int blk;
    int n;
    for (blk = 0; blk < 12; blk++) begin
      gaps_on = (blk % 4) != 3;
      for (n = 0; n < 150; n++) begin
        send_request(random_action(blk % 3), 16'($urandom_range(0, 16'hFFFF)));
        if ($urandom_range(0, 199) == 0) wait_for_drain();
      end
      if (blk == 5) wait_for_drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_noop();
    test_age_order();
    test_full_queue();
    test_random_mix();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d requests and %0d results, %0d items handed out",
             n_requests, n_results, n_taken);
    $display("full rejections %0d, empty rejections %0d, mismatches %0d",
             n_full, n_empty, mismatch_count);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
